### rtl/core/bgu_pkg.sv
// Package: types, constants and helpers for the bicubic grid upsampler.
package bgu_pkg;

    localparam int GRID_SIZE = 256;
    localparam int SPACING   = 16;
    localparam int LAST_NODE = GRID_SIZE / SPACING;
    localparam int STORE_SIDE = 32;
    localparam int IDX_W     = 5;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int VAL_W     = 15;
    localparam int QRY_W     = 9;
    localparam int FRAC_W    = 17;
    localparam int ACC_W     = 40;
    localparam int HEIGHT_W  = 18;
    localparam logic [0:0] REQ_WRITE = 1'b0;
    localparam logic [0:0] REQ_QUERY = 1'b1;
    localparam logic signed [ACC_W-1:0] HEIGHT_MAX = 40'sd131071;
    localparam logic signed [ACC_W-1:0] HEIGHT_MIN = -40'sd131072;

    typedef struct packed {
        logic [0:0]       req_type;
        logic [IDX_W-1:0] node_x;
        logic [IDX_W-1:0] node_z;
        logic [VAL_W-1:0] node_value;
        logic [QRY_W-1:0] query_x;
        logic [QRY_W-1:0] query_z;
    } req_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [0:0]                 saturated;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_ROW, ST_COL, ST_OUT
    } state_t;

    typedef struct packed {
        logic                       start;
        logic [ACC_W-1:0]           v0, v1, v2, v3;
        logic [FRAC_W-1:0]          frac;
    } cub_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [ACC_W-1:0]    res;
    } cub_rsp_t;

    function automatic logic [FRAC_W-1:0] frac_q16(input logic [QRY_W-1:0] q);
        logic [QRY_W-1:0] f;
        logic [31:0] t;
        begin
            f = q % QRY_W'(SPACING);
            t = (32'(f) * 32'd65536 + 32'(SPACING / 2)) / 32'(SPACING);
            return FRAC_W'(t);
        end
    endfunction

    function automatic logic [IDX_W-1:0] clamp_node(input logic signed [QRY_W+1:0] i);
        begin
            if (i < 0) return '0;
            if (i > (QRY_W+2)'(LAST_NODE)) return IDX_W'(LAST_NODE);
            return IDX_W'(i);
        end
    endfunction

endpackage

### rtl/core/bgu_cubic.sv
// Sequential four-point cubic: Horner over three multiply-round steps.
module bgu_cubic (
    input  logic             aclk,
    input  logic             aresetn,
    input  bgu_pkg::cub_req_t req,
    output bgu_pkg::cub_rsp_t rsp
);
    import bgu_pkg::*;

    logic signed [ACC_W-1:0] b_reg, c_reg, d_reg, h_reg;
    logic signed [ACC_W-1:0] b_next, c_next, d_next, h_next;
    logic signed [FRAC_W:0]  f_reg;
    logic [2:0] step_reg, step_next;
    logic signed [ACC_W+FRAC_W:0] prod_reg;
    logic signed [ACC_W-1:0] rnd, va, vb, vc, vd, ab;
    logic done_reg;

    assign va = req.v0;
    assign vb = req.v1;
    assign vc = req.v2;
    assign vd = req.v3;
    assign ab = (vd - vc) - (va - vb);
    assign rnd = ACC_W'((prod_reg + 58'sd32768) >>> 16);

    always_comb begin
        step_next = step_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg; h_next = h_reg;
        if (req.start) begin
            h_next = ab;
            b_next = (va - vb) - ab;
            c_next = vc - va;
            d_next = vb;
            step_next = 3'd1;
        end else begin
            case (step_reg)
                3'd1, 3'd3, 3'd5: step_next = step_reg + 3'd1;
                3'd2: begin h_next = rnd + b_reg; step_next = 3'd3; end
                3'd4: begin h_next = rnd + c_reg; step_next = 3'd5; end
                3'd6: begin h_next = rnd + d_reg; step_next = 3'd0; end
                default: step_next = 3'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= (step_reg == 3'd6) && !req.start;
        end
        b_reg <= b_next; c_reg <= c_next; d_reg <= d_next; h_reg <= h_next;
        if (req.start) f_reg <= $signed({1'b0, req.frac});
        prod_reg <= h_reg * f_reg;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = h_reg;
endmodule

### rtl/core/bgu_store.sv
// Node sample memory: one port, registered read.
module bgu_store (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [bgu_pkg::ADDR_W-1:0] addr,
    input  logic [bgu_pkg::VAL_W-1:0]  wdata,
    output logic [bgu_pkg::VAL_W-1:0]  rdata
);
    import bgu_pkg::*;

    logic [VAL_W-1:0] mem [STORE_SIDE*STORE_SIDE];

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

### rtl/core/bicubic_grid_upsampler_top.sv
// Bicubic grid upsampler: sequencer, node memory and shared cubic unit.
// Write request: accepted without a result; writes can follow back to back.
// Query: per row four memory reads and a row cubic, then a column cubic and
// saturation, after which m_valid rises. The next request is accepted only once
// the result is taken, as the single-port memory and the shared cubic unit serve
// one query at a time. Reset clears control only.
module bicubic_grid_upsampler_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bgu_pkg::req_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output bgu_pkg::rsp_t   m_data
);
    import bgu_pkg::*;

    state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] bx_reg, bz_reg;
    logic [FRAC_W-1:0] fx_reg, fz_reg;
    logic [ACC_W-1:0] v_reg [4];
    logic [ACC_W-1:0] row_reg [4];
    logic [1:0] vi_reg;
    logic rd_pend_reg;
    logic [1:0] rowi_reg;
    rsp_t out_reg;
    logic out_valid_reg;

    logic we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0] rdata;
    cub_req_t creq;
    cub_rsp_t crsp;
    logic [IDX_W-1:0] xi, zi;
    logic signed [ACC_W-1:0] y, yr;
    logic acc_s;

    assign acc_s = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign we = acc_s && s_data.req_type == REQ_WRITE &&
                s_data.node_x <= IDX_W'(LAST_NODE) && s_data.node_z <= IDX_W'(LAST_NODE);

    assign xi = clamp_node($signed({2'b0, QRY_W'(bx_reg)}) + (QRY_W+2)'(cnt_reg[1:0]) - 11'sd1);
    assign zi = clamp_node($signed({2'b0, QRY_W'(bz_reg)}) + (QRY_W+2)'(cnt_reg[3:2]) - 11'sd1);
    assign addr = we ? {s_data.node_x, s_data.node_z} : {xi, zi};

    bgu_store u_store (.aclk(aclk), .we(we), .addr(addr), .wdata(s_data.node_value),
                       .rdata(rdata));
    bgu_cubic u_cubic (.aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));

    assign y = ACC_W'((crsp.res + 40'sd128) >>> 8);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        creq = '0;
        creq.frac = (state_reg == ST_COL) ? fz_reg : fx_reg;
        creq.v0 = v_reg[0]; creq.v1 = v_reg[1]; creq.v2 = v_reg[2]; creq.v3 = v_reg[3];
        case (state_reg)
            ST_IDLE: if (acc_s && s_data.req_type == REQ_QUERY) begin
                state_next = ST_FETCH;
                cnt_next = '0;
            end
            ST_FETCH: if (rd_pend_reg && vi_reg == 2'd3) state_next = ST_ROW;
                      else if (!rd_pend_reg || vi_reg != 2'd3) cnt_next = cnt_reg;
            ST_ROW: if (crsp.done) begin
                if (rowi_reg == 2'd3) begin
                    state_next = ST_COL;
                end else begin
                    state_next = ST_FETCH;
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_COL: if (crsp.done) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_FETCH && rd_pend_reg && vi_reg == 2'd3) begin
            creq.start = 1'b1;
            creq.v3 = ACC_W'({rdata, 8'd0});
        end
        if (state_reg == ST_ROW && crsp.done && rowi_reg == 2'd3) begin
            creq.start = 1'b1;
            creq.frac = fz_reg;
            creq.v0 = row_reg[0]; creq.v1 = row_reg[1]; creq.v2 = row_reg[2];
            creq.v3 = crsp.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            cnt_reg <= '0;
            vi_reg <= '0;
            rowi_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                rowi_reg <= '0;
                vi_reg <= '0;
                rd_pend_reg <= 1'b0;
                cnt_reg <= cnt_next;
            end else if (state_reg == ST_FETCH) begin
                rd_pend_reg <= !(rd_pend_reg && vi_reg == 2'd3);
                if (rd_pend_reg) vi_reg <= vi_reg + 2'd1;
                if (!(rd_pend_reg && vi_reg == 2'd3) && cnt_reg[1:0] != 2'd3)
                    cnt_reg <= cnt_reg + 4'd1;
            end else if (state_reg == ST_ROW && crsp.done) begin
                rowi_reg <= rowi_reg + 2'd1;
                cnt_reg <= cnt_next;
            end
            if (state_reg == ST_OUT) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
        if (acc_s) begin
            bx_reg <= IDX_W'(s_data.query_x / QRY_W'(SPACING));
            bz_reg <= IDX_W'(s_data.query_z / QRY_W'(SPACING));
            fx_reg <= frac_q16(s_data.query_x);
            fz_reg <= frac_q16(s_data.query_z);
        end
        if (state_reg == ST_FETCH && rd_pend_reg)
            v_reg[vi_reg] <= ACC_W'({rdata, 8'd0});
        if (state_reg == ST_ROW && crsp.done) row_reg[rowi_reg] <= crsp.res;
        if (state_reg == ST_COL && crsp.done) yr <= y;
        if (state_reg == ST_OUT) begin
            if (yr > HEIGHT_MAX) begin
                out_reg.height <= HEIGHT_W'(HEIGHT_MAX); out_reg.saturated <= 1'b1;
            end else if (yr < HEIGHT_MIN) begin
                out_reg.height <= HEIGHT_W'(HEIGHT_MIN); out_reg.saturated <= 1'b1;
            end else begin
                out_reg.height <= HEIGHT_W'(yr); out_reg.saturated <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
endmodule

### rtl/core/bgu_checker.sv
// Port-level checker for the bicubic grid upsampler, bound to the top level.
module bgu_assertions (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input bgu_pkg::req_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input bgu_pkg::rsp_t m_data
);
    import bgu_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken while result pending");
    a_write_no_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_WRITE |=> !m_valid)
        else $error("write produced result");
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
        (m_data.height == 18'sh1FFFF || m_data.height == -18'sh20000))
        else $error("saturation flag without clipped height");
endmodule

bind bicubic_grid_upsampler_top bgu_assertions u_bgu_assertions (.*);
